>>> hdl/fixed_slot_free_list_allocator_assert.svh
// Assertion macros shared by the free list allocator RTL.
// Include with the bare file name; the macros are empty in synthesis.
`ifndef FIXED_SLOT_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define FIXED_SLOT_FREE_LIST_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define FSL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fsl: assertion failed");
// next-cycle implication
`define FSL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fsl: assertion failed");
`else
`define FSL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define FSL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/fsl_pkg.sv
// Shared types, codes and widths of the free list slot allocator.
// No dependencies; imported by the front, queue, back and top modules of the block.
package fsl_pkg;

  // default build sizes
  localparam int unsigned MAX_SLOTS_DEF  = 1024;
  localparam int unsigned MAX_STRIDE_DEF = 1024;

  // field widths
  localparam int unsigned OP_W       = 2;
  localparam int unsigned OFF_W      = 20;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned GSLOT_W    = 10;
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned STRIDE_W   = 11;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 11;

  // serial divider: one quotient bit per step
  localparam int unsigned DIV_STEPS = OFF_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS + 1);
  localparam int unsigned REM_W     = STRIDE_W + 1;

  // request queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // operation codes
  localparam logic [OP_W-1:0] OP_INIT  = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_OFFSET = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_CFG    = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_STRIDE = 1'b1;

  // request class decided by the front
  typedef enum logic [2:0] {
    CLS_NOP,
    CLS_INIT,
    CLS_ALLOC,
    CLS_FREE,
    CLS_BAD_CFG
  } cls_t;

  typedef struct packed {
    cls_t             cls;
    logic [OFF_W-1:0] offset;
  } q_entry_t;

  typedef struct packed {
    logic [STRIDE_W-1:0] stride;
    logic [CNT_W-1:0]    count;
  } cfg_t;

endpackage

>>> hdl/fsl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fsl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port, read-first registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/fsl_front.sv
// Front of the allocator: configuration registers, request check and classification.
// Depends on fsl_pkg.
module fsl_front
  import fsl_pkg::*;
#(
  parameter int unsigned MAX_STRIDE = MAX_STRIDE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OP_W-1:0]       in_op,
  input  logic [OFF_W-1:0]      in_payload_offset,
  output logic                  push_valid,
  input  logic                  push_ready,
  output q_entry_t              push_entry,
  output cfg_t                  cfg
);

  logic [CNT_W-1:0]    count_r;
  logic [STRIDE_W-1:0] stride_r;
  logic                cfg_ok;
  cls_t                cls;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= CNT_W'(MAX_SLOTS_DEF);
      stride_r <= STRIDE_W'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SLOT_COUNT:  count_r  <= CNT_W'(cfg_wdata);
        REG_SLOT_STRIDE: stride_r <= STRIDE_W'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // stride must be a nonzero multiple of four within range, count nonzero
  assign cfg_ok = (count_r != '0) && (stride_r != '0) && (stride_r[1:0] == 2'b00)
                  && (32'(stride_r) <= MAX_STRIDE);

  // classify the request
  always_comb begin
    case (in_op)
      OP_INIT:  cls = CLS_INIT;
      OP_ALLOC: cls = CLS_ALLOC;
      OP_FREE:  cls = CLS_FREE;
      default:  cls = CLS_NOP;
    endcase
    if ((in_op != OP_NOP) && !cfg_ok) begin
      cls = CLS_BAD_CFG;
    end
  end

  assign push_valid        = in_valid;
  assign in_stall          = !push_ready;
  assign push_entry.cls    = cls;
  assign push_entry.offset = in_payload_offset;
  assign cfg.count         = count_r;
  assign cfg.stride        = stride_r;

endmodule

>>> hdl/fsl_queue.sv
// Short request queue between the front and the back of the allocator.
// Depends on fsl_pkg and the assertion macro header.
`include "fixed_slot_free_list_allocator_assert.svh"
module fsl_queue
  import fsl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  q_entry_t push_entry,
  output logic     pop_valid,
  input  logic     pop_take,
  output q_entry_t pop_entry
);

  q_entry_t          slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push_fire, pop_fire;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = slot_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_take && pop_valid;

  // pointer and fill updates
  always_comb begin
    wr_ptr_nxt = push_fire ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop_fire ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push_fire && !pop_fire) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_fire && !push_fire) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage, no reset
  always_ff @(posedge clk) begin
    if (push_fire) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  `FSL_ASSERT_NEXT(a_q_fill, clk, rst_n, push_fire && !pop_fire, count_r == $past(count_r) + 1'b1)

endmodule

>>> hdl/fsl_back.sv
// Back of the allocator: free list walker, serial divider and result register.
// Depends on fsl_pkg and the assertion macro header; drives the link store RAM.
`include "fixed_slot_free_list_allocator_assert.svh"
module fsl_back
  import fsl_pkg::*;
#(
  parameter int unsigned MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cfg_t                           cfg,
  input  logic                           pop_valid,
  input  q_entry_t                       pop_entry,
  output logic                           pop_take,
  output logic                           ram_we,
  output logic [$clog2(MAX_SLOTS)-1:0]   ram_waddr,
  output logic [$clog2(MAX_SLOTS+1)-1:0] ram_wdata,
  output logic [$clog2(MAX_SLOTS)-1:0]   ram_raddr,
  input  logic [$clog2(MAX_SLOTS+1)-1:0] ram_rdata,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [STATUS_W-1:0]            out_status,
  output logic [OFF_W-1:0]               out_granted_offset,
  output logic [GSLOT_W-1:0]             out_granted_slot
);

  localparam int unsigned LINK_W = $clog2(MAX_SLOTS + 1);
  localparam int unsigned IDX_W  = $clog2(MAX_SLOTS);
  localparam int unsigned PROD_W = IDX_W + STRIDE_W;
  localparam logic [LINK_W-1:0] NONE_MARK = LINK_W'(MAX_SLOTS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_ALLOC,
    S_DIV,
    S_FREE,
    S_OUT
  } state_t;

  state_t              state_r, state_nxt;
  logic [LINK_W-1:0]   head_r, head_nxt;
  logic [LINK_W-1:0]   k_r, k_nxt;
  logic [REM_W-1:0]    rem_r, rem_nxt;
  logic [OFF_W-1:0]    quo_r, quo_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [OFF_W-1:0]    res_goff_r, res_goff_nxt;
  logic [GSLOT_W-1:0]  res_gslot_r, res_gslot_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [OFF_W-1:0]    out_goff_r, out_goff_nxt;
  logic [GSLOT_W-1:0]  out_gslot_r, out_gslot_nxt;

  logic [31:0]         cnt32;
  logic [LINK_W-1:0]   used;
  logic [IDX_W-1:0]    head_idx;
  logic [PROD_W-1:0]   prod;
  logic [REM_W-1:0]    trial, stride_ext;
  logic                fits;
  logic [31:0]         quo32;
  logic [LINK_W-1:0]   k_inc;

  // slots in use, clipped to the built capacity
  assign cnt32 = 32'(cfg.count);
  assign used  = (cnt32 > MAX_SLOTS) ? LINK_W'(MAX_SLOTS) : LINK_W'(cnt32);

  // the link of the head is read continuously; the read data is registered and ready in the cycle after a pop
  assign head_idx  = head_r[IDX_W-1:0];
  assign ram_raddr = head_idx;
  assign prod      = PROD_W'(head_idx) * PROD_W'(cfg.stride);

  // one restoring division step
  assign stride_ext = REM_W'(cfg.stride);
  assign trial      = {rem_r[REM_W-2:0], quo_r[OFF_W-1]};
  assign fits       = (trial >= stride_ext);
  assign quo32      = 32'(quo_r);
  assign k_inc      = k_r + 1'b1;

  assign pop_take = (state_r == S_IDLE) && pop_valid;

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    k_nxt          = k_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    step_nxt       = step_r;
    res_status_nxt = res_status_r;
    res_goff_nxt   = res_goff_r;
    res_gslot_nxt  = res_gslot_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_goff_nxt   = out_goff_r;
    out_gslot_nxt  = out_gslot_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;

    case (state_r)
      S_IDLE: begin
        if (pop_valid) begin
          res_status_nxt = ST_OK;
          res_goff_nxt   = '0;
          res_gslot_nxt  = '0;
          case (pop_entry.cls)
            CLS_INIT: begin
              k_nxt     = '0;
              state_nxt = S_INIT;
            end
            CLS_ALLOC: begin
              if (head_r >= NONE_MARK) begin
                res_status_nxt = ST_EMPTY;
                state_nxt      = S_OUT;
              end else begin
                state_nxt = S_ALLOC;
              end
            end
            CLS_FREE: begin
              rem_nxt   = '0;
              quo_nxt   = pop_entry.offset;
              step_nxt  = '0;
              state_nxt = S_DIV;
            end
            CLS_BAD_CFG: begin
              res_status_nxt = ST_BAD_CFG;
              state_nxt      = S_OUT;
            end
            default: state_nxt = S_OUT;
          endcase
        end
      end

      // chain each slot to the next, the last one to the none marker
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = k_r[IDX_W-1:0];
        if (k_inc == used) begin
          ram_wdata = NONE_MARK;
          head_nxt  = '0;
          state_nxt = S_OUT;
        end else begin
          ram_wdata = k_inc;
          k_nxt     = k_inc;
        end
      end

      // pop the head, unlink it and grant it
      S_ALLOC: begin
        ram_we        = 1'b1;
        ram_waddr     = head_idx;
        ram_wdata     = NONE_MARK;
        head_nxt      = ram_rdata;
        res_goff_nxt  = OFF_W'(prod);
        res_gslot_nxt = GSLOT_W'(head_idx);
        state_nxt     = S_OUT;
      end

      S_DIV: begin
        rem_nxt  = fits ? trial - stride_ext : trial;
        quo_nxt  = {quo_r[OFF_W-2:0], fits};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = S_FREE;
        end
      end

      // exact multiple and inside the slots in use: push in front of the head; else bad offset
      S_FREE: begin
        if ((rem_r != '0) || (quo32 >= 32'(used))) begin
          res_status_nxt = ST_BAD_OFFSET;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = quo32[IDX_W-1:0];
          ram_wdata = head_r;
          head_nxt  = LINK_W'(quo32);
        end
        state_nxt = S_OUT;
      end

      // hand the result over once the output register is free
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_goff_nxt   = res_goff_r;
          out_gslot_nxt  = res_gslot_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= NONE_MARK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
    k_r          <= k_nxt;
    rem_r        <= rem_nxt;
    quo_r        <= quo_nxt;
    step_r       <= step_nxt;
    res_status_r <= res_status_nxt;
    res_goff_r   <= res_goff_nxt;
    res_gslot_r  <= res_gslot_nxt;
    out_status_r <= out_status_nxt;
    out_goff_r   <= out_goff_nxt;
    out_gslot_r  <= out_gslot_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_granted_offset = out_goff_r;
  assign out_granted_slot   = out_gslot_r;

  `FSL_ASSERT_IMPL(a_init_in_range, clk, rst_n, state_r == S_INIT, k_r < used)
  `FSL_ASSERT_IMPL(a_fail_no_grant, clk, rst_n, out_valid_r && (out_status_r != ST_OK), (out_goff_r == '0) && (out_gslot_r == '0))
  `FSL_ASSERT_NEXT(a_alloc_pops, clk, rst_n, state_r == S_ALLOC, head_r == $past(ram_rdata))

endmodule

>>> hdl/fixed_slot_free_list_allocator.sv
// Fixed-size slot allocator kept as a linked free list. Each request takes an
// operation (init, alloc, free) and gives one result. An alloc reads the link
// of the head from the link store, then pops and unlinks it. A free runs the
// serial divider that turns the byte offset into a slot index one quotient bit
// per cycle (20 steps). An init writes one link store entry per cycle.
// Requests refused for a bad configuration, an alloc on an empty list and the
// unused op code go straight to the result. A two-entry queue in front lets
// requests be taken while the back is busy, and the result register lets the
// back go on while a result waits. The link store needs no clearing after
// reset; the list is empty until an init or a free.
module fixed_slot_free_list_allocator
  import fsl_pkg::*;
#(
  parameter int unsigned MAX_SLOTS  = MAX_SLOTS_DEF,
  parameter int unsigned MAX_STRIDE = MAX_STRIDE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OP_W-1:0]       in_op,
  input  logic [OFF_W-1:0]      in_payload_offset,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STATUS_W-1:0]   out_status,
  output logic [OFF_W-1:0]      out_granted_offset,
  output logic [GSLOT_W-1:0]    out_granted_slot
);

  localparam int unsigned LINK_W = $clog2(MAX_SLOTS + 1);
  localparam int unsigned IDX_W  = $clog2(MAX_SLOTS);

  cfg_t              cfg;
  logic              push_valid, push_ready;
  q_entry_t          push_entry;
  logic              pop_valid, pop_take;
  q_entry_t          pop_entry;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [LINK_W-1:0] ram_wdata, ram_rdata;

  // request check and configuration
  fsl_front #(
    .MAX_STRIDE (MAX_STRIDE)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_payload_offset (in_payload_offset),
    .push_valid        (push_valid),
    .push_ready        (push_ready),
    .push_entry        (push_entry),
    .cfg               (cfg)
  );

  // request queue
  fsl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_take   (pop_take),
    .pop_entry  (pop_entry)
  );

  // list operations and result register
  fsl_back #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .pop_valid          (pop_valid),
    .pop_entry          (pop_entry),
    .pop_take           (pop_take),
    .ram_we             (ram_we),
    .ram_waddr          (ram_waddr),
    .ram_wdata          (ram_wdata),
    .ram_raddr          (ram_raddr),
    .ram_rdata          (ram_rdata),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_granted_offset (out_granted_offset),
    .out_granted_slot   (out_granted_slot)
  );

  // next-slot link store
  fsl_ram #(
    .WIDTH (LINK_W),
    .DEPTH (MAX_SLOTS)
  ) u_link_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

>>> dv/fixed_slot_free_list_allocator_tb.sv
// Testbench for the free list slot allocator: directed and random requests,
// with a scoreboard that tracks the free list and checks every result.
// Depends on fsl_pkg and fixed_slot_free_list_allocator.
`timescale 1ns / 1ps

module fixed_slot_free_list_allocator_tb;
  import fsl_pkg::*;

  localparam int unsigned NO_SLOT = MAX_SLOTS_DEF;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OFF_W-1:0]    offset;
    logic [GSLOT_W-1:0]  slot;
  } grant_t;

  // Tracks the link store, head and registers; queues one grant per request
  class slot_grant_board;
    logic [CNT_W-1:0] next_link [MAX_SLOTS_DEF];
    int unsigned      head_slot;
    int unsigned      slot_count;
    int unsigned      slot_stride;
    grant_t           awaited_grants[$];
    int unsigned      errors;

    function new();
      foreach (next_link[k]) next_link[k] = '0;
      head_slot   = NO_SLOT;
      slot_count  = 1024;
      slot_stride = 64;
      errors      = 0;
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
      if (idx == REG_SLOT_COUNT) slot_count = data;
      else slot_stride = data;
    endfunction

    function grant_t note_request(input logic [OP_W-1:0] op,
                                  input logic [OFF_W-1:0] off);
      grant_t      g;
      int unsigned used;
      int unsigned s;
      bit          cfg_good;
      g        = '0;
      used     = (slot_count > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : slot_count;
      cfg_good = slot_count != 0 && slot_stride != 0 && slot_stride % 4 == 0 &&
                 slot_stride <= MAX_STRIDE_DEF;
      if (op != OP_NOP && !cfg_good) begin
        g.status = ST_BAD_CFG;
      end else begin
        case (op)
          OP_INIT: begin
            for (int unsigned k = 0; k + 1 < used; k++) next_link[k] = CNT_W'(k + 1);
            next_link[used-1] = CNT_W'(NO_SLOT);
            head_slot = 0;
          end
          OP_ALLOC: begin
            if (head_slot >= MAX_SLOTS_DEF) begin
              g.status = ST_EMPTY;
            end else begin
              s = head_slot;
              head_slot = next_link[s];
              next_link[s] = CNT_W'(NO_SLOT);
              g.offset = OFF_W'(s * slot_stride);
              g.slot = GSLOT_W'(s);
            end
          end
          OP_FREE: begin
            s = off / slot_stride;
            if (off % slot_stride != 0 || s >= used) begin
              g.status = ST_BAD_OFFSET;
            end else begin
              next_link[s] = CNT_W'(head_slot);
              head_slot = s;
            end
          end
          default: ;
        endcase
      end
      awaited_grants.push_back(g);
      return g;
    endfunction

    function void check_grant(input logic [STATUS_W-1:0] status,
                              input logic [OFF_W-1:0] offset,
                              input logic [GSLOT_W-1:0] slot);
      grant_t want;
      if (awaited_grants.size() == 0) begin
        $error("result with no request outstanding: status %0d", status);
        errors++;
        return;
      end
      want = awaited_grants.pop_front();
      if (status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, status);
        errors++;
      end
      if (offset !== want.offset) begin
        $error("granted_offset: expected %0d, actual %0d", want.offset, offset);
        errors++;
      end
      if (slot !== want.slot) begin
        $error("granted_slot: expected %0d, actual %0d", want.slot, slot);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [OP_W-1:0]       in_op = OP_NOP;
  logic [OFF_W-1:0]      in_payload_offset = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [STATUS_W-1:0]   out_status;
  logic [OFF_W-1:0]      out_granted_offset;
  logic [GSLOT_W-1:0]    out_granted_slot;

  slot_grant_board  board = new();
  logic [OFF_W-1:0] held_offsets[$];
  int unsigned      tx_idle_pct = 12;
  int unsigned      rx_idle_pct = 80;
  int unsigned      cur_stride = 64;

  fixed_slot_free_list_allocator u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_op              (in_op),
    .in_payload_offset  (in_payload_offset),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_granted_offset (out_granted_offset),
    .out_granted_slot   (out_granted_slot)
  );

  always #1 clk = ~clk;

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct;
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_grant(out_status, out_granted_offset, out_granted_slot);
  end

  // Presents one request, holds it until taken, then notes it.
  // Valid is only dropped for a gap, so it never falls and rises in one step.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [OFF_W-1:0] off);
    grant_t g;
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_op             <= op;
    in_payload_offset <= off;
    do @(posedge clk); while (in_stall);
    g = board.note_request(op, off);
    if (op == OP_INIT) held_offsets.delete();
    else if (op == OP_ALLOC && g.status == ST_OK) held_offsets.push_back(g.offset);
  endtask

  // stop sending and wait until every outstanding request has its result
  task automatic wait_for_grants();
    in_valid <= 1'b0;
    while (board.awaited_grants.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // registers are only touched with the block idle
  task automatic write_settings(input int unsigned cnt, input int unsigned str);
    wait_for_grants();
    cfg_we    <= 1'b1;
    cfg_index <= REG_SLOT_COUNT;
    cfg_wdata <= CFG_DATA_W'(cnt);
    @(posedge clk);
    board.write_reg(REG_SLOT_COUNT, CFG_DATA_W'(cnt));
    cfg_index <= REG_SLOT_STRIDE;
    cfg_wdata <= CFG_DATA_W'(str);
    @(posedge clk);
    board.write_reg(REG_SLOT_STRIDE, CFG_DATA_W'(str));
    cfg_we <= 1'b0;
    cur_stride = str;
    held_offsets.delete();
    @(posedge clk);
  endtask

  task automatic set_idling(input int unsigned sent);
    if (sent < 200) begin
      tx_idle_pct = 12;
      rx_idle_pct = 80;
    end else if (sent < 400) begin
      tx_idle_pct = 80;
      rx_idle_pct = 12;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
  endtask

  initial begin
    int unsigned      sent;
    int unsigned      sel;
    int unsigned      cnt;
    int unsigned      str;
    int unsigned      len;
    int unsigned      used;
    int unsigned      r;
    int unsigned      idx;
    bit               bad_cfg;
    logic [OP_W-1:0]  op;
    logic [OFF_W-1:0] off;

    sent = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, list empty after reset
    send_request(OP_ALLOC, '0);
    send_request(OP_NOP, 20'hFFFFF);
    send_request(OP_FREE, 20'(1023 * 64));    // free before init pushes top slot
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, 20'hFFFFF);        // list exhausted again
    send_request(OP_FREE, 20'd1);             // unaligned
    send_request(OP_FREE, 20'hFFFFF);         // unaligned, all ones
    send_request(OP_FREE, 20'(1024 * 64));    // one past the last slot
    send_request(OP_INIT, 20'hFFFFF);
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, '0);
    send_request(OP_FREE, '0);                // double free goes undetected
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, '0);
    // zero count refuses everything but the unused op
    write_settings(0, 64);
    send_request(OP_INIT, '0);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, '0);
    send_request(OP_NOP, '0);
    // bad strides: zero, unaligned, too large
    write_settings(8, 0);
    send_request(OP_ALLOC, '0);
    write_settings(8, 6);
    send_request(OP_FREE, 20'd12);
    write_settings(8, 1028);
    send_request(OP_INIT, '0);
    // count above capacity, widest stride
    write_settings(2047, 1024);
    send_request(OP_INIT, '0);
    send_request(OP_FREE, 20'(1023 * 1024));
    send_request(OP_ALLOC, '0);

    // Random phases: each picks settings, mostly starts with an init
    while (sent < 600) begin
      sel = $urandom_range(0, 19);
      case (sel)
        0: begin cnt = 1; str = 4; end
        1: begin cnt = 2; str = 1024; end
        2: begin cnt = 1024; str = 4; end
        3: begin cnt = 1024; str = 1024; end
        4: begin cnt = 0; str = 4 * $urandom_range(1, 256); end
        5: begin cnt = $urandom_range(1, 64); str = 0; end
        6: begin cnt = $urandom_range(1, 64); str = 4 * $urandom_range(0, 255) + $urandom_range(1, 3); end
        7: begin cnt = $urandom_range(1, 64); str = 4 * $urandom_range(257, 511); end
        8: begin cnt = $urandom_range(1025, 2047); str = 4 * $urandom_range(1, 256); end
        9: begin cnt = $urandom_range(65, 1024); str = 4 * $urandom_range(1, 256); end
        default: begin cnt = $urandom_range(1, 64); str = 4 * $urandom_range(1, 256); end
      endcase
      bad_cfg = sel >= 4 && sel <= 7;
      set_idling(sent);
      write_settings(cnt, str);
      used = (cnt > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : cnt;
      // skipping the init keeps the old links under the new count
      if ($urandom_range(3) != 0) begin
        send_request(OP_INIT, OFF_W'($urandom));
        sent++;
      end
      len = bad_cfg ? 6 : $urandom_range(20, 60);
      for (int unsigned i = 0; i < len; i++) begin
        set_idling(sent);
        if (sent == 300) wait_for_grants();   // hold-off mid-phase, while the sent count is 300
        r = $urandom_range(99);
        off = OFF_W'($urandom);
        if (r < 3 && used <= 128) begin
          op = OP_INIT;
        end else if (r < 48) begin
          op = OP_ALLOC;
        end else if (r < 92) begin
          op = OP_FREE;
          r = $urandom_range(99);
          if (r < 70 && held_offsets.size() != 0) begin
            idx = $urandom_range(held_offsets.size() - 1);
            off = held_offsets[idx];
            held_offsets.delete(idx);
          end else if (r < 80 && used != 0) begin
            off = OFF_W'($urandom_range(used - 1) * cur_stride);
          end else if (r < 90) begin
            off = OFF_W'($urandom);
          end else if (r < 95 && used != 0) begin
            off = OFF_W'($urandom_range(used - 1) * cur_stride + $urandom_range(1, 3));
          end else begin
            off = OFF_W'((used + $urandom_range(0, 3)) * cur_stride);
          end
        end else begin
          op = OP_NOP;
        end
        send_request(op, off);
        if (op != OP_NOP) sent++;
      end
    end

    wait_for_grants();
    repeat (8) @(posedge clk);
    if (board.errors == 0 && board.awaited_grants.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/fsl_pkg.sv
hdl/fsl_ram.sv
hdl/fsl_front.sv
hdl/fsl_queue.sv
hdl/fsl_back.sv
hdl/fixed_slot_free_list_allocator.sv
dv/fixed_slot_free_list_allocator_tb.sv
